### hw/rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Request types, schedule control bundle, SHA-1 constants and helpers shared
// by the digest top level and the schedule memory.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // Number of chaining (digest) words and the index of the last one.
    localparam int unsigned DigestWords = 5;
    localparam logic [2:0]  LastWordIdx = 3'd4;

    // Index of the final compression round.
    localparam logic [6:0]  RndLast     = 7'd79;

    // Initial chaining values.
    localparam logic [31:0] InitChain [DigestWords] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    // Round constants, one for each group of twenty rounds.
    localparam logic [31:0] RoundK0 = 32'h5a827999;
    localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
    localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
    localparam logic [31:0] RoundK3 = 32'hca62c1d6;

    // Input request: one message byte and the end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       end_of_message;
    } in_item_t;

    // Output request: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Control of the schedule memory and its expansion window.
    typedef struct packed {
        logic        wr_en;
        logic [3:0]  wr_addr;
        logic [31:0] wr_data;
        logic [3:0]  rd_addr;
        logic        use_mem;
        logic        step;
    } sched_ctrl_t;

    // Rotate a 32-bit word left by a constant amount.
    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

### hw/rtl/sha1md_sched.sv
// ----------------------------------------------------------------------------
// SHA-1 schedule memory
// Sixteen-word block buffer with a registered read port, plus the sliding
// window that expands the message schedule for rounds sixteen and up.
// ----------------------------------------------------------------------------
module sha1md_sched (
    input  logic                     aclk,
    input  sha1md_pkg::sched_ctrl_t  ctrl,
    output logic [31:0]              w
);

    // Block buffer memory and its registered read data.
    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    // Last sixteen schedule words; entry 15 is the newest.
    logic [31:0] win_reg [16];

    logic [31:0] w_expand;

    // Block buffer: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_data_reg <= mem[ctrl.rd_addr];
    end

    // Expanded word from W[t-3], W[t-8], W[t-14] and W[t-16].
    assign w_expand = sha1md_pkg::rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);
    assign w        = ctrl.use_mem ? rd_data_reg : w_expand;

    // Window shifts once per round.
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w;
        end
    end

endmodule

### hw/rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 hasher with standard padding and a five-word digest output.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries one message byte (when data_valid
//   is set) and an end_of_message flag that closes the message after that
//   byte. Bytes are packed big-endian into a sixteen-word block memory.
//   A full 64-byte block runs the compression: a load of the working
//   words, 80 rounds at one round per cycle (the round adder chain and the
//   single read port of the block memory set this), and a fold into
//   the chaining words; s_ready is low throughout. A byte that does
//   not finish a block is absorbed while s_ready stays high.
//   On end of message the padding writes one word per cycle from the current
//   word to word 15, then compresses; when fewer than eight bytes remain after
//   the 0x80 byte a second padded block (16 writes, then compression) follows.
//   The DONE state hands the digest to the output buffer, after which the next
//   message may start while the five m_ requests (word 0 first, one per cycle
//   while m_ready is high) drain. If the receiver stalls the previous digest,
//   a closing message waits before that hand-off until the buffer is empty.
//   Reset returns the chaining words to the SHA-1 initial values and empties
//   the output buffer; the block memory needs no clearing.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sha1md_pkg::in_item_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sha1md_pkg::out_item_t  m_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  state_reg,    state_next;
    logic [6:0]  rnd_reg,      rnd_next;
    logic [5:0]  n_reg,        n_next;
    logic [54:0] blk_cnt_reg,  blk_cnt_next;
    logic [23:0] pack_reg,     pack_next;
    logic [3:0]  widx_reg,     widx_next;
    logic        first_reg,    first_next;
    logic        len_blk_reg,  len_blk_next;
    logic        closing_reg,  closing_next;
    logic        end_pend_reg, end_pend_next;
    logic        out_busy_reg, out_busy_next;
    logic [2:0]  out_cnt_reg,  out_cnt_next;
    logic [31:0] chain_reg [sha1md_pkg::DigestWords];
    logic [31:0] chain_next [sha1md_pkg::DigestWords];
    logic [31:0] wk_reg [sha1md_pkg::DigestWords];
    logic [31:0] wk_next [sha1md_pkg::DigestWords];
    logic [31:0] dig_reg [sha1md_pkg::DigestWords];
    logic [31:0] dig_next [sha1md_pkg::DigestWords];

    sha1md_pkg::sched_ctrl_t sched_ctrl;
    logic [31:0] sched_w;
    logic        s_fire;
    logic        m_fire;
    logic [5:0]  n_after;
    logic [63:0] total_bits;
    logic [31:0] pad_word;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp;

    // Schedule memory and expansion window.
    sha1md_sched u_sched (
        .aclk (aclk),
        .ctrl (sched_ctrl),
        .w    (sched_w)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_busy_reg;
    assign m_fire  = out_busy_reg && m_ready;

    // Output request comes straight from the head of the digest buffer.
    assign m_data.digest_word = dig_reg[0];
    assign m_data.word_index  = out_cnt_reg;
    assign m_data.last_word   = (out_cnt_reg == sha1md_pkg::LastWordIdx);

    // Message length in bits: whole blocks, then bytes of the open block.
    assign total_bits = {blk_cnt_reg, n_reg, 3'b000};
    assign n_after    = s_data.data_valid ? n_reg + 6'd1 : n_reg;

    // Padding word for the current write position.
    always_comb begin
        pad_word = '0;
        if (first_reg) begin
            case (n_reg[1:0])
                2'd0:    pad_word = 32'h80000000;
                2'd1:    pad_word = {pack_reg[7:0], 24'h800000};
                2'd2:    pad_word = {pack_reg[15:0], 16'h8000};
                default: pad_word = {pack_reg[23:0], 8'h80};
            endcase
        end else if (len_blk_reg && widx_reg == 4'd14) begin
            pad_word = total_bits[63:32];
        end else if (len_blk_reg && widx_reg == 4'd15) begin
            pad_word = total_bits[31:0];
        end
    end

    // Round function and constant for the current group of twenty rounds.
    always_comb begin
        if (rnd_reg < 7'd20) begin
            f_val = (wk_reg[1] & wk_reg[2]) | (~wk_reg[1] & wk_reg[3]);
            k_val = sha1md_pkg::RoundK0;
        end else if (rnd_reg < 7'd40) begin
            f_val = wk_reg[1] ^ wk_reg[2] ^ wk_reg[3];
            k_val = sha1md_pkg::RoundK1;
        end else if (rnd_reg < 7'd60) begin
            f_val = (wk_reg[1] & wk_reg[2]) | (wk_reg[1] & wk_reg[3])
                  | (wk_reg[2] & wk_reg[3]);
            k_val = sha1md_pkg::RoundK2;
        end else begin
            f_val = wk_reg[1] ^ wk_reg[2] ^ wk_reg[3];
            k_val = sha1md_pkg::RoundK3;
        end
    end

    assign temp = sha1md_pkg::rotl(wk_reg[0], 5) + f_val + wk_reg[4] + k_val + sched_w;

    // Sequencer and output buffer next-state logic.
    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        n_next        = n_reg;
        blk_cnt_next  = blk_cnt_reg;
        pack_next     = pack_reg;
        widx_next     = widx_reg;
        first_next    = first_reg;
        len_blk_next  = len_blk_reg;
        closing_next  = closing_reg;
        end_pend_next = end_pend_reg;
        out_busy_next = out_busy_reg;
        out_cnt_next  = out_cnt_reg;
        chain_next    = chain_reg;
        wk_next       = wk_reg;
        dig_next      = dig_reg;
        sched_ctrl    = '0;

        // Digest buffer drains one word per accepted request.
        if (m_fire) begin
            for (int i = 0; i < sha1md_pkg::DigestWords - 1; i++) begin
                dig_next[i] = dig_reg[i + 1];
            end
            if (out_cnt_reg == sha1md_pkg::LastWordIdx) begin
                out_busy_next = 1'b0;
                out_cnt_next  = '0;
            end else begin
                out_cnt_next = out_cnt_reg + 3'd1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Absorb the byte; a completed word goes to memory.
                    if (s_data.data_valid) begin
                        pack_next = {pack_reg[15:0], s_data.data_byte};
                        n_next    = n_reg + 6'd1;
                        if (n_reg[1:0] == 2'd3) begin
                            sched_ctrl.wr_en   = 1'b1;
                            sched_ctrl.wr_addr = n_reg[5:2];
                            sched_ctrl.wr_data = {pack_reg, s_data.data_byte};
                        end
                    end
                    if (s_data.data_valid && n_reg == 6'd63) begin
                        blk_cnt_next  = blk_cnt_reg + 55'd1;
                        end_pend_next = s_data.end_of_message;
                        state_next    = ST_LOAD;
                    end else if (s_data.end_of_message) begin
                        // Close the message: pad from the current word.
                        widx_next    = n_after[5:2];
                        first_next   = 1'b1;
                        len_blk_next = (n_after[5:3] != 3'd7);
                        closing_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctrl.wr_en   = 1'b1;
                sched_ctrl.wr_addr = widx_reg;
                sched_ctrl.wr_data = pad_word;
                first_next         = 1'b0;
                widx_next          = widx_reg + 4'd1;
                if (widx_reg == 4'd15) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                sched_ctrl.rd_addr = '0;
                wk_next            = chain_reg;
                rnd_next           = '0;
                state_next         = ST_ROUND;
            end
            ST_ROUND: begin
                // One round per cycle; prefetch the next buffered word.
                sched_ctrl.rd_addr = rnd_reg[3:0] + 4'd1;
                sched_ctrl.use_mem = (rnd_reg < 7'd16);
                sched_ctrl.step    = 1'b1;
                wk_next[4]         = wk_reg[3];
                wk_next[3]         = wk_reg[2];
                wk_next[2]         = sha1md_pkg::rotl(wk_reg[1], 30);
                wk_next[1]         = wk_reg[0];
                wk_next[0]         = temp;
                rnd_next           = rnd_reg + 7'd1;
                if (rnd_reg == sha1md_pkg::RndLast) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < sha1md_pkg::DigestWords; i++) begin
                    chain_next[i] = chain_reg[i] + wk_reg[i];
                end
                if (closing_reg) begin
                    if (len_blk_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        // Extra block that holds only zeros and the length.
                        len_blk_next = 1'b1;
                        first_next   = 1'b0;
                        widx_next    = '0;
                        state_next   = ST_PAD;
                    end
                end else if (end_pend_reg) begin
                    // Message ended on a block boundary.
                    end_pend_next = 1'b0;
                    closing_next  = 1'b1;
                    first_next    = 1'b1;
                    len_blk_next  = 1'b1;
                    widx_next     = '0;
                    state_next    = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                // Hand the digest over once the buffer is free.
                if (!out_busy_reg) begin
                    dig_next      = chain_reg;
                    out_busy_next = 1'b1;
                    out_cnt_next  = '0;
                    chain_next    = sha1md_pkg::InitChain;
                    n_next        = '0;
                    blk_cnt_next  = '0;
                    closing_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            n_reg        <= '0;
            blk_cnt_reg  <= '0;
            widx_reg     <= '0;
            first_reg    <= 1'b0;
            len_blk_reg  <= 1'b0;
            closing_reg  <= 1'b0;
            end_pend_reg <= 1'b0;
            out_busy_reg <= 1'b0;
            out_cnt_reg  <= '0;
            chain_reg    <= sha1md_pkg::InitChain;
        end else begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            n_reg        <= n_next;
            blk_cnt_reg  <= blk_cnt_next;
            widx_reg     <= widx_next;
            first_reg    <= first_next;
            len_blk_reg  <= len_blk_next;
            closing_reg  <= closing_next;
            end_pend_reg <= end_pend_next;
            out_busy_reg <= out_busy_next;
            out_cnt_reg  <= out_cnt_next;
            chain_reg    <= chain_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pack_reg <= pack_next;
        wk_reg   <= wk_next;
        dig_reg  <= dig_next;
    end

    // The last round always hands over to the fold.
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == sha1md_pkg::RndLast) |=> (state_reg == ST_FOLD))
        else $error("compression did not fold after the last round");

    // While rounds run the block memory is only read, never written.
    a_no_write_in_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> !sched_ctrl.wr_en)
        else $error("block memory written during compression");

    // The first padding word lands on the word holding the open bytes.
    a_pad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD && first_reg) |-> (widx_reg == n_reg[5:2]))
        else $error("padding started at the wrong word");

    // Taking the last digest word empties the output buffer.
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> !m_valid)
        else $error("digest buffer still busy after its last word");

endmodule

### sim/tb_sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Feeds byte-serial messages (directed corner cases, then random lengths
// around the padding boundaries) through the digest block, computes the
// expected five-word digest of every closed message with a local SHA-1
// model, and checks each digest word as it leaves the block.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

    localparam int StallLimit = 2000;
    localparam int DrainCycles = 50;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sha1md_pkg::in_item_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    sha1md_pkg::out_item_t m_data;

    // Local SHA-1 state that tracks the block.
    logic [31:0] chain_h [sha1md_pkg::DigestWords];
    logic [31:0] block_w [16];
    int          fill_count;
    logic [63:0] msg_bits;

    sha1md_pkg::out_item_t expected_digest [$];
    sha1md_pkg::out_item_t want;
    int          mismatch_count = 0;
    int          useful_requests = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;

    sha1_message_digest i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Write one message byte into the big-endian block buffer.
    task automatic place_byte(input int pos, input logic [7:0] value);
        block_w[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
    endtask

    // Run the 80-round compression over block_w and fold it into chain_h.
    task automatic compress_block();
        logic [31:0] a, b, c, d, e, w, f, k, sum;
        int r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                w = block_w[r];
            end else begin
                w = block_w[(r + 13) & 15] ^ block_w[(r + 8) & 15] ^
                    block_w[(r + 2) & 15] ^ block_w[r & 15];
                w = {w[30:0], w[31]};
                block_w[r & 15] = w;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::RoundK0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::RoundK1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::RoundK2;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::RoundK3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Update the local hash state with one accepted request and queue the
    // digest words when it closes a message.
    task automatic predict_request(input sha1md_pkg::in_item_t req);
        logic [63:0] total_bits;
        int pos;
        int idx;
        sha1md_pkg::out_item_t word;
        if (req.data_valid) begin
            place_byte(fill_count, req.data_byte);
            fill_count++;
            if (fill_count == 64) begin
                compress_block();
                msg_bits += 64'd512;
                fill_count = 0;
            end
        end
        if (req.end_of_message) begin
            total_bits = msg_bits + 64'(fill_count * 8);
            place_byte(fill_count, 8'h80);
            for (pos = fill_count + 1; pos < 64; pos++) begin
                place_byte(pos, 8'h00);
            end
            // No room for the length field: close this block, pad another.
            if (fill_count >= 56) begin
                compress_block();
                for (idx = 0; idx < 16; idx++) begin
                    block_w[idx] = '0;
                end
            end
            block_w[14] = total_bits[63:32];
            block_w[15] = total_bits[31:0];
            compress_block();
            for (idx = 0; idx < sha1md_pkg::DigestWords; idx++) begin
                word.digest_word = chain_h[idx];
                word.word_index  = 3'(idx);
                word.last_word   = (3'(idx) == sha1md_pkg::LastWordIdx);
                expected_digest.push_back(word);
                chain_h[idx] = sha1md_pkg::InitChain[idx];
            end
            fill_count = 0;
            msg_bits   = '0;
        end
    endtask

    // Present one request, hold it until accepted, then predict its effect.
    // Valid stays high afterwards so the next request can follow at once.
    task automatic send_request(input logic [7:0] data_byte, input logic data_valid,
                                input logic end_of_message);
        sha1md_pkg::in_item_t req;
        req.data_byte      = data_byte;
        req.data_valid     = data_valid;
        req.end_of_message = end_of_message;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_request(req);
        if (data_valid || end_of_message) begin
            useful_requests++;
        end
    endtask

    // Send a whole message of random bytes. The closing flag either rides
    // on the last byte or comes alone; empty requests may be mixed in.
    task automatic send_message(input int len, input bit noise_on);
        int n;
        bit close_with_byte;
        close_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (n = 0; n < len; n++) begin
            if (noise_on && $urandom_range(0, 9) == 0) begin
                send_request(8'($urandom), 1'b0, 1'b0);
            end
            send_request(8'($urandom), 1'b1, close_with_byte && (n == len - 1));
        end
        if (!close_with_byte) begin
            send_request(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Empty requests change nothing; a lone close hashes the empty message.
    task automatic test_empty_message();
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'h5a, 1'b0, 1'b1);
    endtask

    // Short messages with byte extremes and both ways of closing.
    task automatic test_short_messages();
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h3c, 1'b0, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
    endtask

    // Random lengths, biased toward the padding and block boundaries.
    task automatic test_random_messages(input int target);
        int start_count;
        int messages;
        int len;
        start_count = useful_requests;
        messages = 0;
        while (useful_requests - start_count < target || messages < 10) begin
            case ($urandom_range(0, 3))
                0, 1: len = $urandom_range(0, 16);
                2: len = $urandom_range(55, 65);
                default: len = $urandom_range(0, 3);
            endcase
            send_message(len, 1'b1);
            messages++;
        end
    endtask

    // Full-rate tail: no idling on either side, lengths just below and at the
    // need for a second padded block, one ending exactly on a block, and an empty one.
    task automatic test_block_boundaries();
        idle_on = 1'b0;
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(64, 1'b0);
        send_message(0, 1'b0);
    endtask

    // Receiver: ready with random stall bursts while idling is enabled.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted digest word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_digest.size() == 0) begin
                $display("%0t: unexpected digest word, expected none, got %h",
                         $time, m_data);
                mismatch_count++;
            end else begin
                want = expected_digest.pop_front();
                if (m_data.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word expected %h, got %h",
                             $time, want.digest_word, m_data.digest_word);
                    mismatch_count++;
                end
                if (m_data.word_index !== want.word_index) begin
                    $display("%0t: word_index expected %0d, got %0d",
                             $time, want.word_index, m_data.word_index);
                    mismatch_count++;
                end
                if (m_data.last_word !== want.last_word) begin
                    $display("%0t: last_word expected %b, got %b",
                             $time, want.last_word, m_data.last_word);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, StallLimit);
            $display("FAIL sha1_message_digest");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        int i;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        for (i = 0; i < sha1md_pkg::DigestWords; i++) begin
            chain_h[i] = sha1md_pkg::InitChain[i];
        end
        for (i = 0; i < 16; i++) begin
            block_w[i] = '0;
        end
        fill_count = 0;
        msg_bits   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_short_messages();
        test_random_messages(100);
        test_block_boundaries();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_digest.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS sha1_message_digest");
        end else begin
            $display("FAIL sha1_message_digest");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_sched.sv
hw/rtl/sha1_message_digest.sv
sim/tb_sha1_message_digest.sv
